// ===== rtl/fbc_pkg.sv =====
// Shared constants and types for the frustum box cull block.
package fbc_pkg;

    localparam int PLANE_COUNT             = 6;
    localparam int PLANE_IDX_W             = 3;
    localparam int NORM_W                  = 32;
    localparam int COORD_W                 = 20;
    localparam int LEVEL_W                 = 4;
    localparam int SECTION_SIZE_DEF        = 16;
    localparam int SECTIONS_PER_COLUMN_DEF = 16;

    // Product of a normal coefficient and a centre coordinate.
    localparam int PROD_W = NORM_W + COORD_W;
    // Twice the largest corner distance, with headroom for the sum of three products.
    localparam int DIST_W = PROD_W + 4;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] off;
    } t_plane;

endpackage

// ===== rtl/fbc_plane_test.sv =====
// One plane test: registered products and bias, then the sign of the farthest corner.
module fbc_plane_test import fbc_pkg::*; #(
    parameter int SECTION_SIZE = SECTION_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_plane                    i_plane,
    input  logic signed [COORD_W-1:0] i_cx,
    input  logic signed [COORD_W-1:0] i_cz,
    input  logic        [LEVEL_W-1:0] i_level,
    output logic                      o_hidden
);

    localparam int YB_W = $clog2(((1 << LEVEL_W) - 1) * SECTION_SIZE + 1);
    localparam int PY_W = NORM_W + YB_W + 1;
    localparam int K_W  = NORM_W + $clog2(SECTION_SIZE) + 4;

    logic        [YB_W-1:0]   ybase;
    logic        [NORM_W-1:0] abs_x;
    logic        [NORM_W-1:0] abs_z;
    logic        [K_W-1:0]    sum_xz;
    logic signed [K_W-1:0]    off2_term;
    logic signed [K_W-1:0]    xz_term;
    logic signed [K_W-1:0]    y_term;
    logic signed [PROD_W-1:0] n_px;
    logic signed [PY_W-1:0]   n_py;
    logic signed [PROD_W-1:0] n_pz;
    logic signed [K_W-1:0]    n_k;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PY_W-1:0]   r_py;
    logic signed [PROD_W-1:0] r_pz;
    logic signed [K_W-1:0]    r_k;
    logic signed [DIST_W-1:0] far_dist;

    // The farthest corner takes the upper bound on each axis where the
    // coefficient is positive, so one sum stands for all eight corners.
    always_comb begin
        ybase     = YB_W'(i_level * SECTION_SIZE);
        abs_x     = i_plane.nx[NORM_W-1] ? NORM_W'(-i_plane.nx) : NORM_W'(i_plane.nx);
        abs_z     = i_plane.nz[NORM_W-1] ? NORM_W'(-i_plane.nz) : NORM_W'(i_plane.nz);
        sum_xz    = K_W'(abs_x) + K_W'(abs_z);
        off2_term = K_W'(i_plane.off) <<< 1;
        xz_term   = $signed(sum_xz * K_W'(SECTION_SIZE));
        if (!i_plane.ny[NORM_W-1]) begin
            y_term = K_W'(i_plane.ny) * K_W'(2 * SECTION_SIZE);
        end else begin
            y_term = '0;
        end
        n_px = PROD_W'(i_plane.nx) * PROD_W'(i_cx);
        n_py = PY_W'(i_plane.ny) * $signed(PY_W'(ybase));
        n_pz = PROD_W'(i_plane.nz) * PROD_W'(i_cz);
        n_k  = off2_term + xz_term + y_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_k  <= n_k;
        end
    end

    always_comb begin
        far_dist = ((DIST_W'(r_px) + DIST_W'(r_py) + DIST_W'(r_pz)) <<< 1) + DIST_W'(r_k);
        o_hidden = far_dist[DIST_W-1];
    end

endmodule

// ===== rtl/frustum_box_cull.sv =====
// Top level of the frustum box cull block: plane store, pipeline and chunk result.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  request | in        | i_valid / o_ready   | i_mode, i_plane_index, normals, offset,
//          |           |                     | i_center_x/z, i_level, i_present, i_last_section
//  result  | out       | o_valid / i_ready   | o_chunk_visible
//
// One request is taken every cycle while o_ready is high; a result passes through the input register,
// the multiplier register and the result register before it appears.
// A plane load takes effect for every test request accepted after it.
// Synchronous reset clears the planes to zero, the chunk flag and all valid bits.
// A stalled result holds the pipeline only once every stage is full.
module frustum_box_cull import fbc_pkg::*; #(
    parameter int SECTION_SIZE        = SECTION_SIZE_DEF,
    parameter int SECTIONS_PER_COLUMN = SECTIONS_PER_COLUMN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic        [PLANE_IDX_W-1:0] i_plane_index,
    input  logic signed [NORM_W-1:0]      i_normal_x,
    input  logic signed [NORM_W-1:0]      i_normal_y,
    input  logic signed [NORM_W-1:0]      i_normal_z,
    input  logic signed [NORM_W-1:0]      i_plane_offset,
    input  logic signed [COORD_W-1:0]     i_center_x,
    input  logic signed [COORD_W-1:0]     i_center_z,
    input  logic        [LEVEL_W-1:0]     i_level,
    input  logic                          i_present,
    input  logic                          i_last_section,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_chunk_visible
);

    t_plane                    r_planes [PLANE_COUNT];
    logic                      r_a_valid;
    t_mode                     r_a_mode;
    logic [PLANE_IDX_W-1:0]    r_a_index;
    t_plane                    r_a_plane;
    logic signed [COORD_W-1:0] r_a_cx;
    logic signed [COORD_W-1:0] r_a_cz;
    logic [LEVEL_W-1:0]        r_a_level;
    logic                      r_a_present;
    logic                      r_a_last;
    logic                      r_b_valid;
    logic                      r_b_ok;
    logic                      r_b_last;
    logic                      r_seen;
    logic                      r_o_valid;
    logic                      r_o_visible;
    logic [PLANE_COUNT-1:0]    hidden;
    logic                      out_free;
    logic                      b_free;
    logic                      a_free;
    logic                      section_visible;
    logic                      n_seen;

    always_comb begin
        out_free        = !r_o_valid || i_ready;
        b_free          = !r_b_valid || out_free;
        a_free          = !r_a_valid || b_free;
        section_visible = r_b_ok && !(|hidden);
        n_seen          = r_seen || section_visible;
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        fbc_plane_test #(
            .SECTION_SIZE(SECTION_SIZE)
        ) u_test (
            .i_clk   (i_clk),
            .i_en    (b_free),
            .i_plane (r_planes[p]),
            .i_cx    (r_a_cx),
            .i_cz    (r_a_cz),
            .i_level (r_a_level),
            .o_hidden(hidden[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_valid) begin
            r_a_mode      <= t_mode'(i_mode);
            r_a_index     <= i_plane_index;
            r_a_plane.nx  <= i_normal_x;
            r_a_plane.ny  <= i_normal_y;
            r_a_plane.nz  <= i_normal_z;
            r_a_plane.off <= i_plane_offset;
            r_a_cx        <= i_center_x;
            r_a_cz        <= i_center_z;
            r_a_level     <= i_level;
            r_a_present   <= i_present;
            r_a_last      <= i_last_section;
        end
        if (b_free) begin
            r_b_ok   <= r_a_present && (32'(r_a_level) < SECTIONS_PER_COLUMN);
            r_b_last <= r_a_last;
        end
        if (r_b_valid && b_free && r_b_last) begin
            r_o_visible <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_planes[p] <= '0;
            end
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_seen    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (r_a_valid && b_free && r_a_mode == MODE_LOAD) begin
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    if (r_a_index == PLANE_IDX_W'(p)) begin
                        r_planes[p] <= r_a_plane;
                    end
                end
            end
            if (b_free) begin
                r_b_valid <= r_a_valid && r_a_mode == MODE_TEST;
            end
            if (r_b_valid && b_free && r_b_last) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_b_valid && b_free) begin
                r_seen <= r_b_last ? 1'b0 : n_seen;
            end
        end
    end

    assign o_ready         = a_free;
    assign o_valid         = r_o_valid;
    assign o_chunk_visible = r_o_visible;

endmodule

// ===== rtl/fbc_checker.sv =====
// Port-level checks for the frustum box cull block, bound to its top level.
module fbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_chunk_visible
);

    // A waiting result stays and keeps its value.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_chunk_visible))
        else $error("stalled result changed or dropped");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Requests are refused only while a result waits to be taken.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request refused without output back-pressure");

    // After reset a result must pass the input, multiplier and result registers before it can appear.
    a_min_latency: assert property (@(posedge i_clk)
        $rose(o_valid) |-> $past(i_rst_n) && $past(i_rst_n, 2))
        else $error("result appeared too soon after reset");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_chunk_visible(o_chunk_visible)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for frustum_box_cull: plane loads and section tests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fbc_pkg::*;

    localparam int SEC_SIZE     = SECTION_SIZE_DEF;
    localparam int SEC_PER_COL  = SECTIONS_PER_COLUMN_DEF;
    localparam int CORNERS      = 8;
    localparam int RANDOM_ITEMS = 1550;
    localparam int TAIL_CYCLES  = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        t_mode                    mode;
        logic [PLANE_IDX_W-1:0]   plane_index;
        logic signed [NORM_W-1:0] nx, ny, nz, off;
        logic signed [COORD_W-1:0] cx, cz;
        logic [LEVEL_W-1:0]       level;
        logic                     present;
        logic                     last;
    } t_request;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_valid        = 1'b0;
    logic                      o_ready;
    logic                      i_mode         = 1'b0;
    logic [PLANE_IDX_W-1:0]    i_plane_index  = '0;
    logic signed [NORM_W-1:0]  i_normal_x     = '0;
    logic signed [NORM_W-1:0]  i_normal_y     = '0;
    logic signed [NORM_W-1:0]  i_normal_z     = '0;
    logic signed [NORM_W-1:0]  i_plane_offset = '0;
    logic signed [COORD_W-1:0] i_center_x     = '0;
    logic signed [COORD_W-1:0] i_center_z     = '0;
    logic [LEVEL_W-1:0]        i_level        = '0;
    logic                      i_present      = 1'b0;
    logic                      i_last_section = 1'b0;
    logic                      o_valid;
    logic                      i_ready        = 1'b0;
    logic                      o_chunk_visible;

    frustum_box_cull i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_plane_index  (i_plane_index),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_plane_offset (i_plane_offset),
        .i_center_x     (i_center_x),
        .i_center_z     (i_center_z),
        .i_level        (i_level),
        .i_present      (i_present),
        .i_last_section (i_last_section),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chunk_visible(o_chunk_visible)
    );

    always #6 i_clk = ~i_clk;

    logic signed [NORM_W-1:0] model_normal [PLANE_COUNT][3] = '{default: '0};
    logic signed [NORM_W-1:0] model_offset [PLANE_COUNT]    = '{default: '0};
    bit                       model_seen_visible            = 1'b0;

    t_request pending_requests [$];
    bit       visible_expected [$];
    t_request cur_req;
    int       requests_total    = 0;
    int       requests_accepted = 0;
    int       mismatches        = 0;
    int       burst_left        = 0;
    int       gap_left          = 0;
    int       rx_mode           = 0;
    int       rx_left           = 0;
    int       rx_tick           = 0;

    // Appends one request to the end of the pending list.
    function automatic void add_request(input t_request r);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    // Applies one request to the local plane store and returns 1 when it closes a chunk.
    function automatic bit predict_chunk_visibility(input t_request r, output bit visible);
        longint xs[2], ys[2], zs[2];
        longint nx, ny, nz, off2, corner_dist;
        int     behind;
        bit     section_seen;
        visible = 1'b0;
        if (r.mode == MODE_LOAD) begin
            if (r.plane_index < PLANE_COUNT) begin
                model_normal[r.plane_index][0] = r.nx;
                model_normal[r.plane_index][1] = r.ny;
                model_normal[r.plane_index][2] = r.nz;
                model_offset[r.plane_index]    = r.off;
            end
            return 1'b0;
        end
        if (r.present && r.level < SEC_PER_COL) begin
            // Corners are kept in half units so that the box edges stay exact.
            xs[0] = 2 * longint'(r.cx) - SEC_SIZE;
            xs[1] = 2 * longint'(r.cx) + SEC_SIZE;
            zs[0] = 2 * longint'(r.cz) - SEC_SIZE;
            zs[1] = 2 * longint'(r.cz) + SEC_SIZE;
            ys[0] = 2 * longint'(r.level) * SEC_SIZE;
            ys[1] = ys[0] + 2 * SEC_SIZE;
            section_seen = 1'b1;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                nx     = model_normal[p][0];
                ny     = model_normal[p][1];
                nz     = model_normal[p][2];
                off2   = 2 * longint'(model_offset[p]);
                behind = 0;
                for (int c = 0; c < CORNERS; c++) begin
                    corner_dist = nx * xs[(c >> 1) & 1] + ny * ys[(c >> 2) & 1]
                                + nz * zs[c & 1] + off2;
                    if (corner_dist < 0)
                        behind++;
                end
                if (behind == CORNERS)
                    section_seen = 1'b0;
            end
            if (section_seen)
                model_seen_visible = 1'b1;
        end
        if (!r.last)
            return 1'b0;
        visible            = model_seen_visible;
        model_seen_visible = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_request plane_load(input int idx,
                                            input logic signed [NORM_W-1:0] nx, ny, nz, off);
        t_request r;
        r.mode        = MODE_LOAD;
        r.plane_index = PLANE_IDX_W'(idx);
        r.nx          = nx;
        r.ny          = ny;
        r.nz          = nz;
        r.off         = off;
        r.cx          = COORD_W'($urandom);
        r.cz          = COORD_W'($urandom);
        r.level       = LEVEL_W'($urandom);
        r.present     = 1'($urandom);
        r.last        = 1'($urandom);
        return r;
    endfunction

    function automatic t_request section_test(input int cx, cz, lvl, input bit present, last);
        t_request r;
        r.mode        = MODE_TEST;
        r.plane_index = PLANE_IDX_W'($urandom);
        r.nx          = $urandom;
        r.ny          = $urandom;
        r.nz          = $urandom;
        r.off         = $urandom;
        r.cx          = COORD_W'(cx);
        r.cz          = COORD_W'(cz);
        r.level       = LEVEL_W'(lvl);
        r.present     = present;
        r.last        = last;
        return r;
    endfunction

    // Request driver: predicts on acceptance and sends in bursts separated by gaps.
    always @(posedge i_clk) begin
        bit next_valid;
        bit result_due;
        bit visible;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                result_due = predict_chunk_visibility(cur_req, visible);
                if (result_due)
                    visible_expected.insert(visible_expected.size(), visible);
                requests_accepted++;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    cur_req        = pending_requests.pop_front();
                    i_mode         <= cur_req.mode;
                    i_plane_index  <= cur_req.plane_index;
                    i_normal_x     <= cur_req.nx;
                    i_normal_y     <= cur_req.ny;
                    i_normal_z     <= cur_req.nz;
                    i_plane_offset <= cur_req.off;
                    i_center_x     <= cur_req.cx;
                    i_center_z     <= cur_req.cz;
                    i_level        <= cur_req.level;
                    i_present      <= cur_req.present;
                    i_last_section <= cur_req.last;
                    next_valid     = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(100, 400);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = $urandom_range(1, 12);
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // Result monitor: checks each result against the oldest prediction and stalls the receiver.
    always @(posedge i_clk) begin
        bit want;
        bit rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (visible_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no request pending, chunk_visible=%0b",
                                 $time, o_chunk_visible);
                end else begin
                    want = visible_expected.pop_front();
                    if (o_chunk_visible !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: chunk_visible expected %0b, got %0b",
                                     $time, want, o_chunk_visible);
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(30, 300);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ($urandom_range(0, 4) == 0);
                default: rdy = ((rx_tick % 7) < 3);
            endcase
            i_ready <= rdy;
        end
    end

    initial begin
        int     n, kind, nlim, px, py, pz, chunks, sections, start_level, idx;
        int     nx, ny, nz, cx, cz;
        longint acc;

        // Zero planes pass everything; an absent last section still closes the chunk.
        add_request(section_test(0, 0, 0, 1, 1));
        add_request(section_test(0, 0, 15, 0, 1));
        add_request(plane_load(6, 0, 0, 0, -1));
        add_request(plane_load(7, 0, 0, 0, -1));
        add_request(section_test(-524288, 524287, 15, 1, 1));
        add_request(plane_load(0, 0, 0, 0, 32'sh8000_0000));
        add_request(section_test(524287, -524288, 0, 1, 1));
        // A box touching the plane is not behind it; one unit further is.
        add_request(plane_load(0, 32'sh0001_0000, 0, 0, 0));
        add_request(section_test(-8, 0, 3, 1, 0));
        add_request(section_test(-9, 0, 3, 1, 1));
        add_request(section_test(-9, 0, 3, 1, 1));
        add_request(section_test(-8, 0, 3, 0, 1));
        add_request(plane_load(1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                               32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        add_request(plane_load(2, 32'sh8000_0000, 32'sh7FFF_FFFF,
                               32'sh8000_0000, 32'sh8000_0000));
        add_request(section_test(524287, 524287, 15, 1, 1));
        add_request(section_test(-524288, -524288, 0, 1, 1));
        add_request(section_test(0, 0, 7, 1, 0));
        add_request(section_test(100, -100, 8, 0, 0));
        add_request(section_test(0, 0, 8, 0, 1));

        // Each frame loads planes through a cluster of sections and then tests whole chunks.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                px   = int'($urandom_range(0, 1048575)) - 524288;
                pz   = int'($urandom_range(0, 1048575)) - 524288;
                nlim = 256;
            end else begin
                px   = int'($urandom_range(0, 2047)) - 1024;
                pz   = int'($urandom_range(0, 2047)) - 1024;
                nlim = 131072;
            end
            py = $urandom_range(0, 256);
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if ($urandom_range(0, 15) == 0)
                    add_request(plane_load($urandom_range(PLANE_COUNT, 7),
                                           $urandom, $urandom, $urandom, $urandom));
                if ($urandom_range(0, 7) != 0) begin
                    idx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, PLANE_COUNT - 1) : p;
                    if (kind == 0) begin
                        add_request(plane_load(idx, $urandom, $urandom,
                                               $urandom, $urandom));
                    end else begin
                        nx  = int'($urandom_range(0, 2 * nlim)) - nlim;
                        ny  = int'($urandom_range(0, 2 * nlim)) - nlim;
                        nz  = int'($urandom_range(0, 2 * nlim)) - nlim;
                        acc = -(longint'(nx) * px + longint'(ny) * py + longint'(nz) * pz)
                            + (longint'($urandom_range(0, 2097152)) - 1048576);
                        add_request(plane_load(idx, nx, ny, nz, acc[31:0]));
                    end
                    n++;
                end
            end
            chunks = $urandom_range(1, 6);
            for (int k = 0; k < chunks; k++) begin
                cx          = px + int'($urandom_range(0, 96)) - 48;
                cz          = pz + int'($urandom_range(0, 96)) - 48;
                sections    = $urandom_range(1, SEC_PER_COL);
                start_level = $urandom_range(0, SEC_PER_COL - 1);
                for (int s = 0; s < sections; s++) begin
                    if ($urandom_range(0, 19) == 0)
                        add_request(section_test($urandom, $urandom, $urandom,
                                                 1'($urandom), 1'($urandom)));
                    else
                        add_request(section_test(cx, cz,
                                                 (start_level + s) % SEC_PER_COL,
                                                 $urandom_range(0, 3) != 0,
                                                 s == sections - 1));
                    n++;
                end
            end
        end
        requests_total = pending_requests.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (requests_accepted < requests_total)
            @(posedge i_clk);
        while (visible_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && visible_expected.size() == 0)
            $display("** frustum_box_cull: PASSED **");
        else
            $display("** frustum_box_cull: FAILED **");
        $finish;
    end

    initial begin
        #4ms;
        $display("Timed out with %0d of %0d requests accepted.",
                 requests_accepted, requests_total);
        $display("** frustum_box_cull: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fbc_pkg.sv
rtl/fbc_plane_test.sv
rtl/frustum_box_cull.sv
rtl/fbc_checker.sv
tb/testbench.sv
